/* rtl/ttlp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlp_pkg: shared types and constants
// Character codes, arithmetic constants, result beat layout and state
// encodings used by the timed-text line parser.
// ----------------------------------------------------------------------------
package ttlp_pkg;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Constant multipliers and their top set bit
  localparam logic [31:0] K_NS_SEC  = 32'd1000000000;
  localparam logic [31:0] K_MIN     = 32'd60;
  localparam logic [5:0]  K_NS_TOP  = 6'd29;
  localparam logic [5:0]  K_MIN_TOP = 6'd5;
  localparam logic [5:0]  DIV_TOP   = 6'd63;

  // Register reset values
  localparam logic [30:0] TIMESCALE_RST = 31'd1000;

  // Result queue depth
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Configuration register index
  typedef enum logic {
    REG_TIMESCALE = 1'b0,
    REG_ABS_MODE  = 1'b1
  } reg_idx_t;

  // Line scan mode
  typedef enum logic [2:0] {
    SM_START,
    SM_TAG,
    SM_TEXT,
    SM_STAMP,
    SM_IGNORE
  } scan_mode_t;

  // Timestamp number phase
  typedef enum logic [1:0] {
    PH_BRACKET,
    PH_BLANKS,
    PH_SIGNED,
    PH_DIGITS
  } phase_t;

  // Timestamp sequencer state
  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_FMUL,
    SQ_DIV,
    SQ_HMUL,
    SQ_HADD,
    SQ_DUR,
    SQ_CTX
  } seq_state_t;

  // One result beat
  typedef struct packed {
    logic        kind;
    logic [7:0]  text_byte;
    logic [63:0] cue_start;
    logic [63:0] cue_duration;
    logic        last;
  } res_t;

  // Finished timestamp handed from the scanner to the sequencer
  typedef struct packed {
    logic [3:0][31:0] fields;
    logic [2:0]       count;
    logic             pend;
  } stamp_t;

  // Sign-extend a 32-bit number to 64 bits
  function automatic logic [63:0] sext32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage

/* rtl/ttlp_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlp_alu: shared 64-bit adder
// Add or subtract; reused by the sequencer for shift-add multiply,
// restoring divide, accumulation and cue timing.
// ----------------------------------------------------------------------------
module ttlp_alu (
  input  logic [63:0] a,
  input  logic [63:0] b,
  input  logic        sub,
  output logic [63:0] sum
);

  // Two's complement subtract via inverted operand and carry in
  assign sum = a + (sub ? ~b : b) + {63'd0, sub};

endmodule

/* rtl/ttlp_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlp_scan: per-byte line scanner
// Tracks line mode, tag skipping, text output and timestamp number matching.
// Hands the matched timestamp to the sequencer at end of line.
// ----------------------------------------------------------------------------
module ttlp_scan (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [7:0]       byte_value,
  input  logic             end_of_line,
  output logic [1:0]       push_n,
  output ttlp_pkg::res_t   res0,
  output ttlp_pkg::res_t   res1,
  output logic             start,
  output ttlp_pkg::stamp_t stamp
);
  import ttlp_pkg::*;

  scan_mode_t       scan_mode, scan_mode_next;
  phase_t           number_phase, number_phase_next;
  logic             text_pending, text_pending_next;
  logic [3:0][31:0] time_fields, time_fields_next;
  logic [2:0]       fields_done, fields_done_next;
  logic             field_negative, field_negative_next;
  logic             match_stopped, match_stopped_next;

  logic [3:0][31:0] fin_fields;
  logic [2:0]       fin_count;
  logic [1:0]       k;
  logic             is_digit;
  logic             is_space;
  logic [31:0]      digit;
  logic [31:0]      cur_field;
  logic [7:0]       sep;

  assign k         = fields_done[1:0];
  assign cur_field = time_fields[k];
  assign is_digit  = (byte_value >= CH_ZERO) && (byte_value <= CH_NINE);
  assign is_space  = (byte_value == CH_SPACE) || ((byte_value >= CH_TAB) && (byte_value <= CH_CR));
  assign digit     = {28'd0, byte_value[3:0]};

  // Separator expected after the number that fin_count closes
  assign sep = (fin_count == 3'd3) ? CH_DOT : CH_COLON;

  // Current number closed out (sign applied, count bumped)
  always_comb begin
    fin_fields = time_fields;
    fin_count  = fields_done;
    if (!match_stopped && number_phase == PH_DIGITS) begin
      if (field_negative) begin
        fin_fields[k] = 32'd0 - cur_field;
      end
      if (fields_done < 3'd4) begin
        fin_count = fields_done + 3'd1;
      end
    end
  end

  assign stamp.fields = fin_fields;
  assign stamp.count  = fin_count;
  assign stamp.pend   = text_pending;

  // Next state and text beats
  always_comb begin
    scan_mode_next      = scan_mode;
    number_phase_next   = number_phase;
    text_pending_next   = text_pending;
    time_fields_next    = time_fields;
    fields_done_next    = fields_done;
    field_negative_next = field_negative;
    match_stopped_next  = match_stopped;
    push_n              = 2'd0;
    start               = 1'b0;
    res0                = '0;
    res1                = '0;
    res0.text_byte      = byte_value;
    res1.text_byte      = byte_value;
    res0.last           = 1'b1;
    res1.last           = 1'b1;

    if (go) begin
      if (end_of_line) begin
        if (scan_mode == SM_STAMP) begin
          start             = 1'b1;
          text_pending_next = 1'b0;
        end
        scan_mode_next      = SM_START;
        number_phase_next   = PH_BRACKET;
        time_fields_next    = '0;
        fields_done_next    = 3'd0;
        field_negative_next = 1'b0;
        match_stopped_next  = 1'b0;
      end else begin
        case (scan_mode)
          SM_START: begin
            if (byte_value == CH_NUL) begin
              scan_mode_next = SM_IGNORE;
            end else if (byte_value == CH_LBRACE) begin
              scan_mode_next = SM_TAG;
            end else if (byte_value == CH_LBRACK) begin
              scan_mode_next    = SM_STAMP;
              number_phase_next = PH_BLANKS;
            end else if (byte_value == CH_SPACE || byte_value == CH_TAB) begin
              scan_mode_next = SM_START;
            end else begin
              // newline goes first when text is already pending
              if (text_pending) begin
                res0.text_byte = CH_NL;
                res0.last      = 1'b0;
                push_n         = 2'd2;
              end else begin
                push_n = 2'd1;
              end
              text_pending_next = 1'b1;
              scan_mode_next    = SM_TEXT;
            end
          end
          SM_TAG: begin
            if (byte_value == CH_NUL) begin
              scan_mode_next = SM_IGNORE;
            end else if (byte_value == CH_RBRACE) begin
              scan_mode_next = SM_START;
            end
          end
          SM_TEXT: begin
            if (byte_value == CH_NUL) begin
              scan_mode_next = SM_IGNORE;
            end else begin
              push_n = 2'd1;
            end
          end
          SM_STAMP: begin
            if (match_stopped || fields_done >= 3'd4) begin
              match_stopped_next = 1'b1;
            end else if (byte_value == CH_NUL) begin
              if (number_phase == PH_DIGITS) begin
                time_fields_next    = fin_fields;
                fields_done_next    = fin_count;
                field_negative_next = 1'b0;
              end
              match_stopped_next = 1'b1;
            end else begin
              case (number_phase)
                PH_BLANKS: begin
                  if (is_space) begin
                    number_phase_next = PH_BLANKS;
                  end else if (byte_value == CH_PLUS || byte_value == CH_MINUS) begin
                    field_negative_next = (byte_value == CH_MINUS);
                    number_phase_next   = PH_SIGNED;
                  end else if (is_digit) begin
                    time_fields_next[k] = digit;
                    number_phase_next   = PH_DIGITS;
                  end else begin
                    match_stopped_next = 1'b1;
                  end
                end
                PH_SIGNED: begin
                  if (is_digit) begin
                    time_fields_next[k] = digit;
                    number_phase_next   = PH_DIGITS;
                  end else begin
                    match_stopped_next = 1'b1;
                  end
                end
                PH_DIGITS: begin
                  if (is_digit) begin
                    // times ten as two shifts, wraps at 32 bits
                    time_fields_next[k] = {cur_field[28:0], 3'd0}
                                        + {cur_field[30:0], 1'b0} + digit;
                  end else begin
                    time_fields_next    = fin_fields;
                    fields_done_next    = fin_count;
                    field_negative_next = 1'b0;
                    if (fin_count < 3'd4 && byte_value == sep) begin
                      number_phase_next = PH_BLANKS;
                    end else begin
                      match_stopped_next = 1'b1;
                    end
                  end
                end
                default: begin
                  match_stopped_next = 1'b1;
                end
              endcase
            end
          end
          default: begin
            scan_mode_next = scan_mode;
          end
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode      <= SM_START;
      number_phase   <= PH_BRACKET;
      text_pending   <= 1'b0;
      time_fields    <= '0;
      fields_done    <= 3'd0;
      field_negative <= 1'b0;
      match_stopped  <= 1'b0;
    end else begin
      scan_mode      <= scan_mode_next;
      number_phase   <= number_phase_next;
      text_pending   <= text_pending_next;
      time_fields    <= time_fields_next;
      fields_done    <= fields_done_next;
      field_negative <= field_negative_next;
      match_stopped  <= match_stopped_next;
    end
  end

endmodule

/* rtl/ttlp_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlp_seq: timestamp sequencer
// Turns h:m:s[.frac] into nanoseconds on one shared adder (shift-add
// multiply, restoring divide), then emits the cue and updates the start.
// ----------------------------------------------------------------------------
module ttlp_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  ttlp_pkg::stamp_t stamp,
  input  logic [30:0]      timescale,
  input  logic             absolute_mode,
  output logic             busy,
  output logic             push,
  output ttlp_pkg::res_t   res
);
  import ttlp_pkg::*;

  seq_state_t       state, state_next;
  logic [5:0]       cnt, cnt_next;
  logic [1:0]       hidx, hidx_next;
  logic [63:0]      acc, acc_next;
  logic [63:0]      x, x_next;
  logic [30:0]      rem, rem_next;
  logic [31:0]      dec, dec_next;
  logic [3:0][31:0] f, f_next;
  logic             pend, pend_next;
  logic [63:0]      ctx, ctx_next;

  logic [63:0] alu_a, alu_b, alu_sum;
  logic        alu_sub;
  logic [31:0] mul_k;
  logic        mbit;
  logic [31:0] shift_in;
  logic [30:0] divisor;
  logic        div_ok;
  logic [63:0] addend;

  ttlp_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .sum (alu_sum)
  );

  assign busy     = (state != SQ_IDLE);
  assign divisor  = (timescale == 31'd0) ? 31'd1 : timescale;
  assign shift_in = {rem, acc[63]};
  assign div_ok   = ~alu_sum[63];
  assign mul_k    = (state == SQ_FMUL || hidx == 2'd2) ? K_NS_SEC : K_MIN;
  assign mbit     = mul_k[cnt[4:0]];

  // Horner addend per pass
  always_comb begin
    case (hidx)
      2'd0:    addend = sext32(f[1]);
      2'd1:    addend = sext32(f[2]);
      default: addend = sext32(dec);
    endcase
  end

  // Shared adder operand select
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      SQ_FMUL, SQ_HMUL: begin
        alu_a = {acc[62:0], 1'b0};
        alu_b = mbit ? x : 64'd0;
      end
      SQ_DIV: begin
        alu_a   = {32'd0, shift_in};
        alu_b   = {33'd0, divisor};
        alu_sub = 1'b1;
      end
      SQ_HADD: begin
        alu_a = acc;
        alu_b = addend;
      end
      SQ_DUR: begin
        alu_a   = acc;
        alu_b   = absolute_mode ? ctx : 64'd0;
        alu_sub = absolute_mode;
      end
      SQ_CTX: begin
        alu_a = ctx;
        alu_b = acc;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  // Next state and outputs
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    hidx_next  = hidx;
    acc_next   = acc;
    x_next     = x;
    rem_next   = rem;
    dec_next   = dec;
    f_next     = f;
    pend_next  = pend;
    ctx_next   = ctx;
    push       = 1'b0;
    res              = '0;
    res.kind         = 1'b1;
    res.cue_start    = ctx;
    res.cue_duration = alu_sum;
    res.last         = 1'b1;

    case (state)
      SQ_IDLE: begin
        if (start) begin
          f_next    = stamp.fields;
          pend_next = stamp.pend;
          acc_next  = '0;
          if (stamp.count < 3'd3) begin
            state_next = SQ_DUR;
          end else if (stamp.count == 3'd4) begin
            x_next     = sext32(stamp.fields[3]);
            cnt_next   = K_NS_TOP;
            state_next = SQ_FMUL;
          end else begin
            dec_next   = '0;
            x_next     = sext32(stamp.fields[0]);
            hidx_next  = 2'd0;
            cnt_next   = K_MIN_TOP;
            state_next = SQ_HMUL;
          end
        end
      end
      // fraction times 1e9, one multiplier bit a cycle
      SQ_FMUL: begin
        acc_next = alu_sum;
        if (cnt == 6'd0) begin
          cnt_next   = DIV_TOP;
          rem_next   = '0;
          state_next = SQ_DIV;
        end else begin
          cnt_next = cnt - 6'd1;
        end
      end
      // restoring divide by timescale, one quotient bit a cycle
      SQ_DIV: begin
        rem_next = div_ok ? alu_sum[30:0] : shift_in[30:0];
        acc_next = {acc[62:0], div_ok};
        if (cnt == 6'd0) begin
          dec_next   = {acc[30:0], div_ok};
          x_next     = sext32(f[0]);
          acc_next   = '0;
          hidx_next  = 2'd0;
          cnt_next   = K_MIN_TOP;
          state_next = SQ_HMUL;
        end else begin
          cnt_next = cnt - 6'd1;
        end
      end
      // running value times 60 or 1e9
      SQ_HMUL: begin
        acc_next = alu_sum;
        if (cnt == 6'd0) begin
          state_next = SQ_HADD;
        end else begin
          cnt_next = cnt - 6'd1;
        end
      end
      SQ_HADD: begin
        if (hidx == 2'd2) begin
          acc_next   = alu_sum;
          state_next = SQ_DUR;
        end else begin
          x_next     = alu_sum;
          acc_next   = '0;
          cnt_next   = (hidx == 2'd0) ? K_MIN_TOP : K_NS_TOP;
          hidx_next  = hidx + 2'd1;
          state_next = SQ_HMUL;
        end
      end
      // cue beat when text is pending
      SQ_DUR: begin
        push       = pend;
        state_next = SQ_CTX;
      end
      SQ_CTX: begin
        if (acc != 64'd0) begin
          ctx_next = absolute_mode ? acc : alu_sum;
        end
        state_next = SQ_IDLE;
      end
      default: begin
        state_next = SQ_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SQ_IDLE;
      ctx   <= '0;
    end else begin
      state <= state_next;
      ctx   <= ctx_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    cnt  <= cnt_next;
    hidx <= hidx_next;
    acc  <= acc_next;
    x    <= x_next;
    rem  <= rem_next;
    dec  <= dec_next;
    f    <= f_next;
    pend <= pend_next;
  end

endmodule

/* rtl/timed_text_line_parser.sv */
`timescale 1ns / 1ps
// A text beat is visible the cycle after its input beat is taken; a cue beat follows its
// end of line once the sequencer has finished with the time stamp.
// Text and tag bytes are taken one per cycle while the sequencer is idle and the 4-entry
// result queue has room; a timestamp end of line holds input until the sequencer is done
// (bit-serial multiplies with three numbers, plus a 64-step divide with a fraction, all on one 64-bit adder).
// Reset (rst, synchronous) restores timescale 1000, absolute mode, start 0, empty queue.
// ----------------------------------------------------------------------------
// timed_text_line_parser: subtitle line parser top level
// Configuration port, result queue, byte scanner and timestamp sequencer.
// ----------------------------------------------------------------------------
module timed_text_line_parser (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_value,
  input  logic        end_of_line,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [7:0]  text_byte,
  output logic [63:0] cue_start,
  output logic [63:0] cue_duration,
  output logic        last
);
  import ttlp_pkg::*;

  logic [30:0] timescale;
  logic        absolute_mode;
  reg_idx_t    reg_idx;
  logic        wr_en;

  logic        go;
  logic [1:0]  scan_push_n;
  res_t        scan_res0, scan_res1;
  logic        seq_start;
  stamp_t      stamp;
  logic        seq_busy;
  logic        seq_push;
  res_t        seq_res;

  res_t                fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr, rd_ptr;
  logic [FIFO_AW:0]    count;
  logic [1:0]          push_n;
  res_t                wr_res0;
  logic                pop;
  res_t                head;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      timescale     <= TIMESCALE_RST;
      absolute_mode <= 1'b1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TIMESCALE: timescale     <= pwdata[30:0];
        REG_ABS_MODE:  absolute_mode <= pwdata[0];
        default:       timescale     <= timescale;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TIMESCALE: prdata = {1'b0, timescale};
      REG_ABS_MODE:  prdata = {31'd0, absolute_mode};
      default:       prdata = '0;
    endcase
  end

  // Input handshake: hold off while the sequencer runs or the queue is low on room
  assign in_stall = seq_busy || (count > (FIFO_AW + 1)'(FIFO_DEPTH - 2));
  assign go       = in_valid && !in_stall;

  ttlp_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .go          (go),
    .byte_value  (byte_value),
    .end_of_line (end_of_line),
    .push_n      (scan_push_n),
    .res0        (scan_res0),
    .res1        (scan_res1),
    .start       (seq_start),
    .stamp       (stamp)
  );

  ttlp_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (seq_start),
    .stamp         (stamp),
    .timescale     (timescale),
    .absolute_mode (absolute_mode),
    .busy          (seq_busy),
    .push          (seq_push),
    .res           (seq_res)
  );

  // Result queue; scanner and sequencer never push in the same cycle
  assign push_n  = seq_push ? 2'd1 : scan_push_n;
  assign wr_res0 = seq_push ? seq_res : scan_res0;
  assign pop     = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_mem[wr_ptr] <= wr_res0;
    end
    if (push_n == 2'd2) begin
      fifo_mem[wr_ptr + FIFO_AW'(1)] <= scan_res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      count <= count + (FIFO_AW + 1)'(push_n) - (FIFO_AW + 1)'(pop);
    end
  end

  // Output beat from queue head
  assign head         = fifo_mem[rd_ptr];
  assign out_valid    = (count != '0);
  assign kind         = head.kind;
  assign text_byte    = head.text_byte;
  assign cue_start    = head.cue_start;
  assign cue_duration = head.cue_duration;
  assign last         = head.last;

endmodule

/* tb/sv/ttlp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlp_checker: result predictor and scoreboard for the timed-text parser
// Follows configuration writes and accepted input beats, and predicts the text
// and cue beats that each one causes. Every accepted result beat is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ttlp_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  byte_value,
  input  logic        end_of_line,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        kind,
  input  logic [7:0]  text_byte,
  input  logic [63:0] cue_start,
  input  logic [63:0] cue_duration,
  input  logic        last,
  output int          fail_count,
  output int          beats_owed
);
  import ttlp_pkg::*;

  localparam logic [63:0] NS_SEC    = 64'd1000000000;
  localparam logic [63:0] NS_MIN    = 64'd60000000000;
  localparam logic [63:0] NS_HOUR   = 64'd3600000000000;

  // configuration copy
  logic [30:0] ts_units;
  logic        abs_times;

  // line scanner copy
  scan_mode_t  line_mode;
  logic        text_open;
  logic [63:0] cue_origin;
  logic [31:0] stamp_num [4];
  logic [2:0]  nums_done;
  phase_t      num_phase;
  logic        num_neg;
  logic        stamp_halt;

  res_t parsed_beats[$];
  int   mismatches = 0;
  int   owed = 0;

  assign fail_count = mismatches;
  assign beats_owed = owed;

  task automatic report_mismatch(input string what);
    $display("%0t ERROR %s", $time, what);
    mismatches++;
  endtask

  function automatic logic [63:0] sx(input logic signed [31:0] v);
    logic signed [63:0] w;
    w = v;
    return w;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void restart_line();
    line_mode  = SM_START;
    foreach (stamp_num[i]) stamp_num[i] = '0;
    nums_done  = '0;
    num_phase  = PH_BRACKET;
    num_neg    = 1'b0;
    stamp_halt = 1'b0;
  endfunction

  function automatic void close_number();
    logic [1:0] k;
    k = nums_done[1:0];
    if (num_neg) stamp_num[k] = -stamp_num[k];
    num_neg = 1'b0;
    if (nums_done < 3'd4) nums_done++;
  endfunction

  function automatic void emit(input logic k, input logic [7:0] b,
                               input logic [63:0] s, input logic [63:0] d);
    res_t r;
    r.kind         = k;
    r.text_byte    = b;
    r.cue_start    = s;
    r.cue_duration = d;
    r.last         = 1'b0;
    parsed_beats.push_back(r);
  endfunction

  // one character of a bracketed time stamp, sscanf %d style
  function automatic void stamp_char(input logic [7:0] c);
    logic [1:0] k;
    k = nums_done[1:0];
    if (stamp_halt || nums_done >= 3'd4) begin
      stamp_halt = 1'b1;
    end else if (c == CH_NUL) begin
      if (num_phase == PH_DIGITS) close_number();
      stamp_halt = 1'b1;
    end else begin
      case (num_phase)
        PH_BLANKS: begin
          if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            // leading whitespace is allowed
          end else if (c == CH_PLUS || c == CH_MINUS) begin
            num_neg   = (c == CH_MINUS);
            num_phase = PH_SIGNED;
          end else if (is_digit(c)) begin
            stamp_num[k] = c - CH_ZERO;
            num_phase    = PH_DIGITS;
          end else begin
            stamp_halt = 1'b1;
          end
        end
        PH_SIGNED: begin
          if (is_digit(c)) begin
            stamp_num[k] = c - CH_ZERO;
            num_phase    = PH_DIGITS;
          end else begin
            stamp_halt = 1'b1;
          end
        end
        PH_DIGITS: begin
          if (is_digit(c)) begin
            stamp_num[k] = stamp_num[k] * 32'd10 + (c - CH_ZERO);
          end else begin
            close_number();
            // separators: colon, colon, then dot before the fraction
            if (nums_done < 3'd4 && c == ((nums_done == 3'd3) ? CH_DOT : CH_COLON))
              num_phase = PH_BLANKS;
            else
              stamp_halt = 1'b1;
          end
        end
        default: stamp_halt = 1'b1;
      endcase
    end
  endfunction

  // time stamp in ns, wrapping at 64 bits; zero with fewer than three numbers
  function automatic logic [63:0] stamp_ns();
    logic [63:0] div, frac64;
    logic [31:0] frac32;
    if (!stamp_halt && num_phase == PH_DIGITS) close_number();
    if (nums_done < 3'd3) return 64'd0;
    frac32 = '0;
    if (nums_done == 3'd4) begin
      div    = (ts_units == '0) ? 64'd1 : {33'd0, ts_units};
      frac64 = (sx(stamp_num[3]) * NS_SEC) / div;
      frac32 = frac64[31:0];
    end
    return sx(stamp_num[0]) * NS_HOUR + sx(stamp_num[1]) * NS_MIN
         + sx(stamp_num[2]) * NS_SEC + sx(frac32);
  endfunction

  function automatic void parse_beat(input logic [7:0] c, input logic eol);
    int          n0;
    logic [63:0] t;
    res_t        r;
    n0 = parsed_beats.size();
    if (eol) begin
      if (line_mode == SM_STAMP) begin
        t = stamp_ns();
        if (text_open) emit(1'b1, 8'd0, cue_origin, abs_times ? t - cue_origin : t);
        text_open = 1'b0;
        if (t != 64'd0) cue_origin = abs_times ? t : cue_origin + t;
      end
      restart_line();
    end else begin
      case (line_mode)
        SM_START: begin
          if (c == CH_NUL) line_mode = SM_IGNORE;
          else if (c == CH_LBRACE) line_mode = SM_TAG;
          else if (c == CH_LBRACK) begin
            line_mode = SM_STAMP;
            num_phase = PH_BLANKS;
          end else if (c == CH_SPACE || c == CH_TAB) begin
            // blank before the first real character
          end else begin
            if (text_open) emit(1'b0, CH_NL, 64'd0, 64'd0);
            emit(1'b0, c, 64'd0, 64'd0);
            text_open = 1'b1;
            line_mode = SM_TEXT;
          end
        end
        SM_TAG: begin
          if (c == CH_NUL) line_mode = SM_IGNORE;
          else if (c == CH_RBRACE) line_mode = SM_START;
        end
        SM_TEXT: begin
          if (c == CH_NUL) line_mode = SM_IGNORE;
          else emit(1'b0, c, 64'd0, 64'd0);
        end
        SM_STAMP: stamp_char(c);
        default: ;
      endcase
    end
    // flag the final beat of this input
    if (parsed_beats.size() > n0) begin
      r = parsed_beats.pop_back();
      r.last = 1'b1;
      parsed_beats.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      ts_units   = TIMESCALE_RST;
      abs_times  = 1'b1;
      text_open  = 1'b0;
      cue_origin = '0;
      restart_line();
      parsed_beats.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_TIMESCALE, 2'b00}) ts_units = pwdata[30:0];
        else if (paddr == {REG_ABS_MODE, 2'b00}) abs_times = pwdata[0];
      end
      if (in_valid && !in_stall) parse_beat(byte_value, end_of_line);
      // result beats against predictions, oldest first
      if (out_valid && !out_stall) begin
        if (parsed_beats.size() == 0) begin
          report_mismatch($sformatf("unexpected beat kind=%0d byte=%02h", kind, text_byte));
        end else begin
          want = parsed_beats.pop_front();
          if (kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
          if (text_byte !== want.text_byte)
            report_mismatch($sformatf("text_byte %02h, expected %02h",
                                      text_byte, want.text_byte));
          if (cue_start !== want.cue_start)
            report_mismatch($sformatf("cue_start %0d, expected %0d",
                                      cue_start, want.cue_start));
          if (cue_duration !== want.cue_duration)
            report_mismatch($sformatf("cue_duration %0d, expected %0d",
                                      cue_duration, want.cue_duration));
          if (last !== want.last)
            report_mismatch($sformatf("last %0d, expected %0d", last, want.last));
        end
      end
    end
    owed <= parsed_beats.size();
  end

endmodule

/* tb/sv/tb_timed_text_line_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timed_text_line_parser: regression bench for the timed-text line parser
// Feeds subtitle lines (text, tags, time stamps, broken and noisy lines) under
// several timescale and time-mode settings, with random idle bursts on both
// channels and one long output hold-off. The checker scores every result.
// ----------------------------------------------------------------------------
module tb_timed_text_line_parser;
  import ttlp_pkg::*;

  localparam int          DRAIN_CYCLES  = 200;
  localparam int          CYCLE_LIMIT   = 1500000;
  localparam int          BEATS_PER_SET = 250;
  localparam int          NUM_SETS      = 6;
  localparam int          HOLD_SET      = 4;
  localparam int          HOLD_CYCLES   = 400;
  localparam logic [7:0]  CH_RBRACK     = 8'h5D;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  byte_value = '0;
  logic        end_of_line = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        kind;
  logic [7:0]  text_byte;
  logic [63:0] cue_start;
  logic [63:0] cue_duration;
  logic        last;

  int          fail_count;
  int          beats_owed;
  int unsigned cycle_count = 0;
  int          beats_sent = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  logic [7:0]  line_q[$];

  always #5 clk = ~clk;

  timed_text_line_parser u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .byte_value   (byte_value),
    .end_of_line  (end_of_line),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .text_byte    (text_byte),
    .cue_start    (cue_start),
    .cue_duration (cue_duration),
    .last         (last)
  );

  ttlp_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .byte_value   (byte_value),
    .end_of_line  (end_of_line),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .text_byte    (text_byte),
    .cue_start    (cue_start),
    .cue_duration (cue_duration),
    .last         (last),
    .fail_count   (fail_count),
    .beats_owed   (beats_owed)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timed_text_line_parser regression: fail");
      $finish;
    end
  end

  // output stall: random bursts, one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // one input beat, with an optional idle burst ahead of it
  task automatic send_beat(input logic [7:0] b, input logic eol);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    byte_value  <= b;
    end_of_line <= eol;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_line();
    int i;
    for (i = 0; i < line_q.size(); i++) send_beat(line_q[i], 1'b0);
    send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic load_str(input string s);
    int i;
    line_q.delete();
    for (i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  // wait for every predicted beat, then for any result-free stamp work
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (beats_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] tag_char(input bit allow_nul);
    logic [7:0] b;
    do b = 8'($urandom_range(allow_nul ? 0 : 1, 255)); while (b == CH_RBRACE);
    return b;
  endfunction

  // random line: mostly well-formed stamps and text, the rest odd cases
  task automatic build_line();
    int         pick, nums, i, j, len;
    logic [7:0] b;
    line_q.delete();
    pick = $urandom_range(0, 99);
    // leading blanks and closed tags
    if (pick < 70 || pick >= 94) begin
      len = (pick >= 94 || $urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 0;
      for (i = 0; i < len; i++) begin
        if ($urandom_range(0, 1)) begin
          line_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        end else begin
          line_q.push_back(CH_LBRACE);
          for (j = $urandom_range(0, 4); j > 0; j--) line_q.push_back(tag_char(1'b0));
          line_q.push_back(CH_RBRACE);
        end
      end
    end
    if (pick < 35) begin
      // time stamp
      line_q.push_back(CH_LBRACK);
      j = $urandom_range(0, 19);
      nums = (j < 9) ? 4 : (j < 16) ? 3 : j - 16;
      for (i = 0; i < nums; i++) begin
        if ($urandom_range(0, 3) == 0)
          line_q.push_back($urandom_range(0, 3) == 0 ? CH_SPACE
                                                     : 8'($urandom_range(CH_TAB, CH_CR)));
        if ($urandom_range(0, 3) == 0)
          line_q.push_back($urandom_range(0, 2) == 0 ? CH_MINUS : CH_PLUS);
        // now and then a long number that wraps
        len = ($urandom_range(0, 11) == 0) ? $urandom_range(8, 12)
                                           : $urandom_range(1, (i == 3) ? 4 : 2);
        for (j = 0; j < len; j++) line_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        if (i < nums - 1 || $urandom_range(0, 7) == 0) begin
          if ($urandom_range(0, 19) == 0) line_q.push_back(8'($urandom_range(0, 255)));
          else line_q.push_back(i < 2 ? CH_COLON : CH_DOT);
        end
      end
      j = $urandom_range(0, 15);
      if (j < 11) begin
        line_q.push_back(CH_RBRACK);
      end else if (j < 13) begin
        for (i = $urandom_range(1, 4); i > 0; i--) line_q.push_back(8'($urandom_range(0, 255)));
      end else if (j == 13) begin
        line_q.push_back(CH_NUL);
        for (i = $urandom_range(0, 3); i > 0; i--) line_q.push_back(8'($urandom_range(0, 255)));
      end
    end else if (pick < 70) begin
      // text, with an occasional zero byte cutting it short
      do b = 8'($urandom_range(1, 255));
      while (b == CH_LBRACE || b == CH_LBRACK || b == CH_SPACE || b == CH_TAB);
      line_q.push_back(b);
      for (i = $urandom_range(0, 10); i > 0; i--)
        line_q.push_back($urandom_range(0, 15) == 0 ? CH_NUL : 8'($urandom_range(1, 255)));
    end else if (pick < 80) begin
      for (i = $urandom_range(0, 10); i > 0; i--) line_q.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 88) begin
      // tag never closed
      line_q.push_back(CH_LBRACE);
      for (i = $urandom_range(0, 6); i > 0; i--) line_q.push_back(tag_char(1'b1));
    end else if (pick < 94) begin
      line_q.push_back(CH_NUL);
      for (i = $urandom_range(0, 4); i > 0; i--) line_q.push_back(8'($urandom_range(0, 255)));
    end
    // rare corruption anywhere in the line
    if (line_q.size() > 0 && $urandom_range(0, 24) == 0)
      line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
  endtask

  initial begin
    int p, goal;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed lines under reset settings
    load_str("A");
    send_line();
    load_str("\t{}[1:2:3.5]");
    send_line();
    line_q = '{8'hFF, CH_NUL};
    send_line();
    load_str("{");
    send_line();
    load_str("B");
    send_line();
    drain();

    // random lines under each setting
    for (p = 0; p < NUM_SETS; p++) begin
      case (p)
        1: begin
          write_reg(REG_TIMESCALE, 32'd1);
          write_reg(REG_ABS_MODE, 32'd0);
        end
        2: begin
          write_reg(REG_TIMESCALE, 32'h7FFF_FFFF);
          write_reg(REG_ABS_MODE, 32'd1);
        end
        3: begin
          write_reg(REG_TIMESCALE, 32'd0);
          write_reg(REG_ABS_MODE, 32'd0);
        end
        4: begin
          write_reg(REG_TIMESCALE, $urandom_range(1, 32'h7FFF_FFFF));
          write_reg(REG_ABS_MODE, $urandom_range(0, 1));
        end
        5: begin
          write_reg(REG_TIMESCALE, 32'd1000000000);
          write_reg(REG_ABS_MODE, 32'd1);
        end
        default: ;
      endcase
      if (p == HOLD_SET) hold_req = 1'b1;
      if (p == NUM_SETS - 1) quiet = 1'b1;
      goal = beats_sent + BEATS_PER_SET;
      while (beats_sent < goal) begin
        build_line();
        send_line();
      end
      drain();
    end

    if (fail_count == 0 && beats_owed == 0) begin
      $display("timed_text_line_parser regression: pass");
    end else begin
      $display("timed_text_line_parser regression: fail");
    end
    $finish;
  end

endmodule
